// File: hw/rtl/gtp_tcp_payload_locator_unit_defines.svh
// Assertion macros used by the top level of the payload locator.
// Expects clk and rst_n in the scope of every use.
`ifndef GTP_TCP_PAYLOAD_LOCATOR_UNIT_DEFINES_SVH
`define GTP_TCP_PAYLOAD_LOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GTPPL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtppl assertion failed");

// antecedent implies consequent in the next cycle
`define GTPPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtppl assertion failed");

`endif

// File: hw/rtl/gtppl_pkg.sv
// Package of the payload locator: transaction structs, parse stages,
// status codes and header size constants. No dependencies.
package gtppl_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 16384;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 2);
  localparam int unsigned OUT_W           = 15;

  localparam int unsigned ETH_LEN        = 14;
  localparam int unsigned UDP_LEN        = 8;
  localparam int unsigned GTP_LEN        = 8;
  localparam int unsigned TCP_DOFF_BYTE  = 12;
  localparam int unsigned MIN_HDR_WORDS  = 5;
  localparam logic [7:0]  GTP_E_FLAG     = 8'h04;
  localparam logic [7:0]  LO_NIB_MASK    = 8'h0F;
  localparam logic [7:0]  HI_NIB_MASK    = 8'hF0;

  typedef enum logic [2:0] {
    STG_IP   = 3'd0,
    STG_TCP  = 3'd1,
    STG_DONE = 3'd2,
    STG_OIP  = 3'd3,
    STG_GTP  = 3'd4,
    STG_EXT  = 3'd5
  } stage_t;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_MALFORMED = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] payload_offset;
    logic [OUT_W-1:0] payload_length;
  } out_item_t;

endpackage

// File: hw/rtl/gtp_tcp_payload_locator_unit.sv
// Top level of the TCP payload locator: input register, header walker,
// result register. Depends on gtppl_pkg and the three gtppl_* modules.
//
//   channel | ports                              | transaction
//   in      | in_valid, in_ready, in_data        | one frame byte, frame_end flag
//   out     | out_valid, out_ready, out_data     | status, payload offset, length
//   cfg     | cfg_we, cfg_wdata                  | tunnel_mode, one cycle write
//
// One byte per cycle sustained unless a final byte waits; a result is formed combinationally
// by the walker's stage compare and position adders and held in the result register.
// Synchronous active-low reset; tunnel_mode resets to plain IPv4+TCP.
// Non-final bytes keep flowing while a result waits; a final byte waits
// in the input register until the result register is free.
`include "gtp_tcp_payload_locator_unit_defines.svh"

module gtp_tcp_payload_locator_unit
  import gtppl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      hold_valid;
  in_item_t  hold_data;
  logic      step_en;
  logic      slot_free;
  logic      res_valid;
  out_item_t res_data;

  assign step_en = hold_valid && (!hold_data.frame_end || slot_free);

  gtppl_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (step_en),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  gtppl_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .item      (hold_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  gtppl_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `GTPPL_ASSERT_IMPL(a_stall_only_on_full_out, !in_ready, out_valid && !out_ready)
  `GTPPL_ASSERT_IMPL(a_unused_fields_zero,
    out_valid && out_data.status != STATUS_FOUND,
    out_data.payload_offset == '0 && out_data.payload_length == '0)
  `GTPPL_ASSERT_IMPL(a_found_has_bytes,
    out_valid && out_data.status == STATUS_FOUND, out_data.payload_length != '0)

endmodule

// File: hw/rtl/gtppl_in_stage.sv
// Input register of the payload locator: holds one byte transaction.
// Depends on gtppl_pkg.
module gtppl_in_stage
  import gtppl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     take,
  output logic     hold_valid,
  output in_item_t hold_data
);

  logic     valid_r, valid_nxt;
  in_item_t data_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_valid || (valid_r && !take);
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_ready ? in_valid : valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// File: hw/rtl/gtppl_walker.sv
// Header walker: mode register, per-frame parse state and result logic.
// Depends on gtppl_pkg.
module gtppl_walker
  import gtppl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      step_en,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res_data
);

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

  logic             tunnel_r;
  stage_t           stage_r, stage_nxt, cur_stage;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_adv;
  logic [POS_W-1:0] hend_r, hend_nxt, cur_hend;
  logic             pend_r, pend_nxt, cur_pend;
  logic             mal_r, mal_nxt, cur_mal;
  logic [POS_W-1:0] fo_r, fo_nxt, cur_fo;
  logic             first;
  logic [3:0]       lo_nib, hi_nib;
  logic [POS_W-1:0] lo_words, hi_words, ip_end;

  assign first    = (pos_r == '0);
  assign lo_nib   = 4'(item.data_byte & LO_NIB_MASK);
  assign hi_nib   = 4'((item.data_byte & HI_NIB_MASK) >> 4);
  assign lo_words = POS_W'({lo_nib, 2'b00});
  assign hi_words = POS_W'({hi_nib, 2'b00});
  assign ip_end   = pos_r + lo_words;

  always_comb begin
    cur_stage = first ? (tunnel_r ? STG_OIP : STG_IP) : stage_r;
    cur_hend  = first ? (tunnel_r ? POS_W'(ETH_LEN) : '0) : hend_r;
    cur_pend  = first ? 1'b0 : pend_r;
    cur_mal   = first ? 1'b0 : mal_r;
    cur_fo    = first ? '0 : fo_r;

    stage_nxt = cur_stage;
    hend_nxt  = cur_hend;
    pend_nxt  = cur_pend;
    mal_nxt   = cur_mal;
    fo_nxt    = cur_fo;
    pos_adv   = pos_r;

    if (step_en) begin
      if (pos_r < MAX_POS) begin
        pos_adv = pos_r + POS_W'(1);
        if (!cur_mal && cur_stage != STG_DONE && pos_r == cur_hend) begin
          case (cur_stage)
            STG_OIP: begin
              if (lo_nib < 4'(MIN_HDR_WORDS)) begin
                mal_nxt = 1'b1;
              end else begin
                hend_nxt  = ip_end + POS_W'(UDP_LEN);
                stage_nxt = STG_GTP;
              end
            end
            STG_GTP: begin
              hend_nxt = pos_r + POS_W'(GTP_LEN);
              if ((item.data_byte & GTP_E_FLAG) != '0) begin
                stage_nxt = STG_EXT;
                pend_nxt  = 1'b1;
              end else begin
                stage_nxt = STG_IP;
              end
            end
            STG_EXT: begin
              if (cur_pend) begin
                hend_nxt = pos_r + POS_W'(1);
                if (item.data_byte == '0) begin
                  stage_nxt = STG_IP;
                end else begin
                  pend_nxt = 1'b0;
                end
              end else begin
                hend_nxt = pos_r + POS_W'(1) + POS_W'(item.data_byte);
                pend_nxt = 1'b1;
              end
            end
            STG_IP: begin
              if (lo_nib < 4'(MIN_HDR_WORDS)) begin
                mal_nxt = 1'b1;
              end else begin
                fo_nxt    = ip_end;
                hend_nxt  = ip_end + POS_W'(TCP_DOFF_BYTE);
                stage_nxt = STG_TCP;
              end
            end
            STG_TCP: begin
              if (hi_nib < 4'(MIN_HDR_WORDS)) begin
                mal_nxt = 1'b1;
              end else begin
                fo_nxt    = cur_fo + hi_words;
                stage_nxt = STG_DONE;
              end
            end
            default: begin
              stage_nxt = cur_stage;
            end
          endcase
        end
      end else begin
        pos_adv = MAX_POS + POS_W'(1);
      end
    end
  end

  assign res_valid = step_en && item.frame_end;
  assign pos_nxt   = res_valid ? '0 : pos_adv;

  always_comb begin
    res_data.status         = STATUS_FOUND;
    res_data.payload_offset = '0;
    res_data.payload_length = '0;
    if (pos_adv > MAX_POS) begin
      res_data.status = STATUS_TOO_LONG;
    end else if (mal_nxt || stage_nxt != STG_DONE || pos_adv < fo_nxt) begin
      res_data.status = STATUS_MALFORMED;
    end else if (pos_adv == fo_nxt) begin
      res_data.status = STATUS_EMPTY;
    end else begin
      res_data.payload_offset = OUT_W'(fo_nxt);
      res_data.payload_length = OUT_W'(pos_adv - fo_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tunnel_r <= 1'b0;
      stage_r  <= STG_IP;
      pos_r    <= '0;
      hend_r   <= '0;
      pend_r   <= 1'b0;
      mal_r    <= 1'b0;
      fo_r     <= '0;
    end else begin
      if (cfg_we) begin
        tunnel_r <= cfg_wdata;
      end
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
      hend_r  <= hend_nxt;
      pend_r  <= pend_nxt;
      mal_r   <= mal_nxt;
      fo_r    <= fo_nxt;
    end
  end

endmodule

// File: hw/rtl/gtppl_out_stage.sv
// Result register of the payload locator: holds one result transaction.
// Depends on gtppl_pkg.
module gtppl_out_stage
  import gtppl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res_data,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = res_valid || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res_data;
    end
  end

endmodule

// File: dv/tb_top.sv
// Self-checking bench for gtp_tcp_payload_locator_unit: frames are built byte by byte in
// plain and tunnel mode; each frame-end result is compared to a built-in header walker or
// to the table's values (typed frames). Depends on gtppl_pkg and the RTL of the locator.
module tb_top;
  import gtppl_pkg::*;

  typedef struct {
    bit      mode;
    int      oihl;
    bit      gtp_e;
    int      n_ext;
    int      ext_len;
    int      ihl;
    int      doff;
    int      pay;
    int      cut;
    bit      midcfg;
    bit      typed;
    status_t exp_st;
    int      exp_off;
    int      exp_len;
  } frame_spec_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  gtp_tcp_payload_locator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cut: 0 keeps the built length, -1 cuts at a random point, else the frame length
  frame_spec_t directed_frames [0:21] = '{
    '{0,  5, 0, 0,   0,  5,  5,     0,     0, 0, 1, STATUS_EMPTY,     0,     0},
    '{0,  5, 0, 0,   0,  5,  5,     1,     0, 0, 1, STATUS_FOUND,    40,     1},
    '{0,  5, 0, 0,   0, 15, 15,    10,     0, 0, 1, STATUS_FOUND,   120,    10},
    '{0,  5, 0, 0,   0,  4,  5,    20,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  0,  5,    20,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  5,  4,    20,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  5,  0,    20,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  5,  5,    20,     1, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  5,  5,    20,    39, 0, 1, STATUS_MALFORMED, 0,     0},
    '{0,  5, 0, 0,   0,  5,  5,    20,    32, 0, 1, STATUS_MALFORMED, 0,     0},
    '{1,  5, 0, 0,   0,  5,  5,     5,     0, 0, 1, STATUS_FOUND,    90,     5},
    '{1,  4, 0, 0,   0,  5,  5,     5,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{1,  5, 0, 0,   0,  2,  5,     5,     0, 0, 1, STATUS_MALFORMED, 0,     0},
    '{1, 15, 1, 2,   0,  6,  7,     9,     0, 0, 0, STATUS_FOUND,     0,     0},
    '{1,  5, 1, 1, 255,  5,  5,     2,     0, 0, 0, STATUS_FOUND,     0,     0},
    '{1,  5, 1, 0,   0,  5,  5,     3,     0, 0, 1, STATUS_FOUND,    91,     3},
    '{1,  5, 1, 2,   4,  5,  5,     8,    60, 0, 0, STATUS_FOUND,     0,     0},
    '{0,  5, 0, 0,   0,  5,  6,     7,     0, 1, 0, STATUS_FOUND,     0,     0},
    '{1,  6, 1, 1,   3,  5,  5,     4,     0, 1, 0, STATUS_FOUND,     0,     0},
    '{0,  5, 0, 0,   0,  5,  5, 16344,     0, 0, 1, STATUS_FOUND,    40, 16344},
    '{0,  5, 0, 0,   0,  5,  5, 16345,     0, 0, 1, STATUS_TOO_LONG,  0,     0},
    '{1,  3, 0, 0,   0,  5,  5,     0, 16400, 0, 1, STATUS_TOO_LONG,  0,     0}
  };

  logic [7:0]  frame_bytes [$];
  out_item_t   pending_locations [$];
  int          idle_phase;
  bit          typed_pending;
  out_item_t   typed_location;
  int          mismatch_count;
  int          frames_sent;
  int          bytes_sent;
  int          status_seen [4];

  // header walker state
  bit          tunnel_reg;
  stage_t      walk_stage;
  int unsigned walk_pos;
  int unsigned walk_hdr_end;
  bit          walk_type_next;
  bit          walk_bad;
  int unsigned walk_found;

  function automatic bit locate_payload(input logic [7:0] b, input logic last,
                                        output out_item_t loc);
    int unsigned nib;
    int unsigned total;
    loc = '0;
    if (walk_pos == 0) begin
      walk_type_next = 1'b0;
      walk_bad       = 1'b0;
      walk_found     = 0;
      walk_stage     = tunnel_reg ? STG_OIP : STG_IP;
      walk_hdr_end   = tunnel_reg ? ETH_LEN : 0;
    end
    if (walk_pos < MAX_FRAME_BYTES) begin
      if (!walk_bad && walk_stage != STG_DONE && walk_pos == walk_hdr_end) begin
        case (walk_stage)
          STG_OIP: begin
            nib = b & LO_NIB_MASK;
            if (nib < MIN_HDR_WORDS) begin
              walk_bad = 1'b1;
            end else begin
              walk_hdr_end = walk_pos + nib * 4 + UDP_LEN;
              walk_stage   = STG_GTP;
            end
          end
          STG_GTP: begin
            walk_hdr_end = walk_pos + GTP_LEN;
            if ((b & GTP_E_FLAG) != 0) begin
              walk_stage     = STG_EXT;
              walk_type_next = 1'b1;
            end else begin
              walk_stage = STG_IP;
            end
          end
          STG_EXT: begin
            if (walk_type_next) begin
              walk_hdr_end = walk_pos + 1;
              if (b == 8'h00) walk_stage = STG_IP;
              else walk_type_next = 1'b0;
            end else begin
              walk_hdr_end   = walk_pos + 1 + b;
              walk_type_next = 1'b1;
            end
          end
          STG_IP: begin
            nib = b & LO_NIB_MASK;
            if (nib < MIN_HDR_WORDS) begin
              walk_bad = 1'b1;
            end else begin
              walk_found   = walk_pos + nib * 4;
              walk_hdr_end = walk_found + TCP_DOFF_BYTE;
              walk_stage   = STG_TCP;
            end
          end
          STG_TCP: begin
            nib = (b & HI_NIB_MASK) >> 4;
            if (nib < MIN_HDR_WORDS) begin
              walk_bad = 1'b1;
            end else begin
              walk_found = walk_found + nib * 4;
              walk_stage = STG_DONE;
            end
          end
          default: ;
        endcase
      end
      walk_pos++;
    end else begin
      walk_pos = MAX_FRAME_BYTES + 1;
    end
    if (!last) return 1'b0;
    total    = walk_pos;
    walk_pos = 0;
    if (total > MAX_FRAME_BYTES) begin
      loc.status = STATUS_TOO_LONG;
    end else if (walk_bad || walk_stage != STG_DONE || total < walk_found) begin
      loc.status = STATUS_MALFORMED;
    end else if (total == walk_found) begin
      loc.status = STATUS_EMPTY;
    end else begin
      loc.status         = STATUS_FOUND;
      loc.payload_offset = OUT_W'(walk_found);
      loc.payload_length = OUT_W'(total - walk_found);
    end
    return 1'b1;
  endfunction

  function automatic bit pick(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_rests();
    case (idle_phase)
      1:       return pick(48);
      3:       return pick(13);
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_phase)
      2:       return pick(48);
      3:       return pick(13);
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= !receiver_stalls();
  end

  function automatic void check_field(input string name, input int exp_v, input logic [14:0] act);
    if (act !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_locations.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d offset %0d length %0d",
                 $time, out_data.status, out_data.payload_offset, out_data.payload_length);
        mismatch_count++;
      end else begin
        want = pending_locations.pop_front();
        check_field("status", want.status, 15'(out_data.status));
        check_field("payload_offset", want.payload_offset, out_data.payload_offset);
        check_field("payload_length", want.payload_length, out_data.payload_length);
        status_seen[want.status]++;
      end
    end
  end

  task automatic push_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic build_frame(input frame_spec_t s);
    int hw;
    int n;
    int len;
    frame_bytes.delete();
    if (s.mode) begin
      push_random(ETH_LEN);
      frame_bytes.push_back({4'($urandom), 4'(s.oihl)});
      hw = (s.oihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : s.oihl;
      push_random(hw * 4 - 1 + UDP_LEN);
      frame_bytes.push_back((8'($urandom) & ~GTP_E_FLAG) | (s.gtp_e ? GTP_E_FLAG : 8'h00));
      push_random(GTP_LEN - 1);
      if (s.gtp_e) begin
        for (int k = 0; k < s.n_ext; k++) begin
          if (s.ext_len >= 0) n = s.ext_len;
          else n = pick(15) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          frame_bytes.push_back(8'($urandom_range(1, 255)));
          frame_bytes.push_back(8'(n));
          push_random(n);
        end
        frame_bytes.push_back(8'h00);
      end
    end
    frame_bytes.push_back({4'($urandom), 4'(s.ihl)});
    hw = (s.ihl < MIN_HDR_WORDS) ? MIN_HDR_WORDS : s.ihl;
    push_random(hw * 4 - 1 + TCP_DOFF_BYTE);
    frame_bytes.push_back({4'(s.doff), 4'($urandom)});
    hw = (s.doff < MIN_HDR_WORDS) ? MIN_HDR_WORDS : s.doff;
    push_random(hw * 4 - TCP_DOFF_BYTE - 1 + s.pay);
    len = frame_bytes.size();
    if (s.cut == -1) len = $urandom_range(1, frame_bytes.size() - 1);
    else if (s.cut > 0) len = s.cut;
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    out_item_t loc;
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (locate_payload(b, last, loc)) begin
      pending_locations.push_back(typed_pending ? typed_location : loc);
    end
  endtask

  // hold the sender until every result is out, then let the pipeline settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_locations.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tunnel_mode(input bit m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tunnel_reg  = m;
  endtask

  task automatic send_frame(input frame_spec_t s);
    if (s.mode != tunnel_reg) begin
      wait_for_results();
      write_tunnel_mode(s.mode);
    end
    build_frame(s);
    typed_pending  = s.typed;
    typed_location = '{s.exp_st, OUT_W'(s.exp_off), OUT_W'(s.exp_len)};
    foreach (frame_bytes[i]) begin
      if (s.midcfg && i == frame_bytes.size() / 2) begin
        wait_for_results();
        write_tunnel_mode(!tunnel_reg);
      end
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  function automatic frame_spec_t random_frame(input bit mode);
    frame_spec_t s;
    int r;
    r         = $urandom_range(0, 99);
    s.mode    = mode;
    s.oihl    = $urandom_range(5, 15);
    s.gtp_e   = $urandom_range(0, 1);
    s.n_ext   = $urandom_range(0, 3);
    s.ext_len = -1;
    s.ihl     = pick(50) ? 5 : $urandom_range(5, 15);
    s.doff    = pick(50) ? 5 : $urandom_range(5, 15);
    s.pay     = pick(20) ? 0 : $urandom_range(1, 40);
    s.cut     = 0;
    s.midcfg  = 1'b0;
    s.typed   = 1'b0;
    s.exp_st  = STATUS_FOUND;
    s.exp_off = 0;
    s.exp_len = 0;
    if (r >= 85) begin
      s.oihl = $urandom_range(0, 15);
      s.ihl  = $urandom_range(0, 15);
      s.doff = $urandom_range(0, 15);
      s.cut  = $urandom_range(1, 120);
    end else if (r >= 68) begin
      case ($urandom_range(0, 3))
        0:       s.oihl = $urandom_range(0, 4);
        1:       s.ihl  = $urandom_range(0, 4);
        2:       s.doff = $urandom_range(0, 4);
        default: s.cut  = -1;
      endcase
    end
    return s;
  endfunction

  initial begin
    bit blk_mode;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    out_ready      = 1'b0;
    idle_phase     = 0;
    mismatch_count = 0;
    frames_sent    = 0;
    bytes_sent     = 0;
    typed_pending  = 1'b0;
    tunnel_reg     = 1'b0;
    walk_pos       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_tunnel_mode(1'b0);

    foreach (directed_frames[i]) send_frame(directed_frames[i]);
    typed_pending = 1'b0;

    for (int blk = 0; blk < 8; blk++) begin
      wait_for_results();
      idle_phase = blk % 4;
      blk_mode   = (blk < 2) ? blk[0] : bit'($urandom_range(0, 1));
      write_tunnel_mode(blk_mode);
      repeat (7) send_frame(random_frame(blk_mode));
    end

    wait_for_results();
    $display("Sent %0d frames (%0d bytes) in plain and tunnel mode under four idle patterns",
             frames_sent, bytes_sent);
    $display("Results: %0d found, %0d empty, %0d malformed, %0d too long",
             status_seen[STATUS_FOUND], status_seen[STATUS_EMPTY],
             status_seen[STATUS_MALFORMED], status_seen[STATUS_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending_locations.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
